FILE: rtl/core/midi_byte_to_usb_midi_packet_top_defines.svh
// Assertion helpers for the MIDI to USB-MIDI packet block.
`ifndef MIDI_BYTE_TO_USB_MIDI_PACKET_TOP_DEFINES_SVH
`define MIDI_BYTE_TO_USB_MIDI_PACKET_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MBU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbu assertion failed");
`define MBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbu assertion failed");
`else
`define MBU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MBU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/mbu_pkg.sv
package mbu_pkg;

  localparam logic [7:0] MIDI_ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] MIDI_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] MIDI_SYSEX_START  = 8'hF0;
  localparam logic [7:0] MIDI_SYS_MTC      = 8'hF1;
  localparam logic [7:0] MIDI_SYS_SONG_SEL = 8'hF3;
  localparam logic [7:0] MIDI_STATUS_MIN   = 8'h80;

  localparam logic [3:0] CMD_PROGRAM       = 4'hC;
  localparam logic [3:0] CMD_CHAN_PRESSURE = 4'hD;

  localparam logic [3:0] CIN_SYSEX_CONT    = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1    = 4'h5;
  localparam logic [3:0] CIN_SINGLE_BYTE   = 4'hF;

  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] event_byte_a;
    logic [7:0] event_byte_b;
    logic [7:0] event_byte_c;
  } pkt_t;

endpackage

FILE: rtl/core/mbu_if.sv
interface mbu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

interface mbu_pkt_if;
  logic       valid;
  logic       ready;
  logic [3:0] code_index;
  logic [7:0] event_byte_a;
  logic [7:0] event_byte_b;
  logic [7:0] event_byte_c;

  modport source (output valid, output code_index, output event_byte_a,
                  output event_byte_b, output event_byte_c, input ready);
  modport sink (input valid, input code_index, input event_byte_a,
                input event_byte_b, input event_byte_c, output ready);
endinterface

FILE: rtl/core/mbu_core.sv
module mbu_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    midi_byte,
  output logic          emit,
  output mbu_pkg::pkt_t pkt
);
  import mbu_pkg::*;

  logic [7:0]      rs_r, rs_nxt;
  logic [1:0]      exp_len_r, exp_len_nxt;
  logic [1:0]      coll_r, coll_nxt;
  logic [3:0]      pcode_r, pcode_nxt;
  logic [2:0][7:0] pb_r, pb_nxt;
  logic            sx_active_r, sx_active_nxt;
  logic [1:0]      sx_fill_r, sx_fill_nxt;
  logic            hit;

  always_comb begin
    logic [1:0]      fill;
    logic [1:0]      coll_inc;
    logic [2:0][7:0] pb_w;
    logic [3:0]      cmd;
    rs_nxt        = rs_r;
    exp_len_nxt   = exp_len_r;
    coll_nxt      = coll_r;
    pcode_nxt     = pcode_r;
    pb_nxt        = pb_r;
    sx_active_nxt = sx_active_r;
    sx_fill_nxt   = sx_fill_r;
    hit           = 1'b0;
    pkt           = '0;
    fill          = (sx_fill_r == 2'd3) ? 2'd2 : sx_fill_r;
    coll_inc      = coll_r + 2'd1;
    pb_w          = pb_r;
    cmd           = midi_byte[7:4];
    if (midi_byte == MIDI_ACTIVE_SENSE) begin
      hit = 1'b0;
    end else if (sx_active_r) begin
      if (midi_byte >= MIDI_REALTIME_MIN) begin
        hit = 1'b0;
      end else if (midi_byte == MIDI_SYSEX_START) begin
        if (fill != 2'd0) begin
          hit              = 1'b1;
          pkt.code_index   = CIN_SYSEX_CONT;
          pkt.event_byte_a = pb_r[0];
          pkt.event_byte_b = (fill > 2'd1) ? pb_r[1] : 8'h00;
        end
        sx_active_nxt = 1'b1;
        pb_nxt        = {8'h00, 8'h00, MIDI_SYSEX_START};
        sx_fill_nxt   = 2'd1;
      end else begin
        pb_w[fill] = midi_byte;
        pb_nxt     = pb_w;
        if (midi_byte[7]) begin
          hit              = 1'b1;
          pkt.code_index   = CIN_SYSEX_END1 + {2'b00, fill};
          pkt.event_byte_a = pb_w[0];
          pkt.event_byte_b = (fill >= 2'd1) ? pb_w[1] : 8'h00;
          pkt.event_byte_c = (fill >= 2'd2) ? pb_w[2] : 8'h00;
          sx_active_nxt    = 1'b0;
          sx_fill_nxt      = 2'd0;
        end else if (fill == 2'd2) begin
          hit              = 1'b1;
          pkt.code_index   = CIN_SYSEX_CONT;
          pkt.event_byte_a = pb_w[0];
          pkt.event_byte_b = pb_w[1];
          pkt.event_byte_c = pb_w[2];
          sx_fill_nxt      = 2'd0;
        end else begin
          sx_fill_nxt = fill + 2'd1;
        end
      end
    end else if (midi_byte == MIDI_SYSEX_START) begin
      exp_len_nxt   = LEN_NONE;
      coll_nxt      = 2'd0;
      sx_active_nxt = 1'b1;
      pb_nxt        = {8'h00, 8'h00, MIDI_SYSEX_START};
      sx_fill_nxt   = 2'd1;
    end else if (midi_byte >= MIDI_REALTIME_MIN) begin
      hit              = 1'b1;
      pkt.code_index   = CIN_SINGLE_BYTE;
      pkt.event_byte_a = midi_byte;
    end else if (midi_byte > MIDI_SYSEX_START) begin
      if (exp_len_r == LEN_NONE) begin
        exp_len_nxt = (midi_byte == MIDI_SYS_MTC || midi_byte == MIDI_SYS_SONG_SEL) ?
                      LEN_TWO : LEN_THREE;
        pcode_nxt   = CIN_SINGLE_BYTE;
        pb_nxt      = {8'h00, 8'h00, midi_byte};
        coll_nxt    = 2'd1;
      end
    end else if (midi_byte >= MIDI_STATUS_MIN) begin
      exp_len_nxt = (cmd == CMD_PROGRAM || cmd == CMD_CHAN_PRESSURE) ? LEN_TWO : LEN_THREE;
      rs_nxt      = midi_byte;
      pcode_nxt   = cmd;
      pb_nxt      = {8'h00, 8'h00, midi_byte};
      coll_nxt    = 2'd1;
    end else if (exp_len_r == LEN_NONE) begin
      if (rs_r != 8'h00) begin
        pcode_nxt = rs_r[7:4];
        pb_nxt    = {8'h00, midi_byte, rs_r};
        if (rs_r[7:4] == CMD_PROGRAM || rs_r[7:4] == CMD_CHAN_PRESSURE) begin
          exp_len_nxt      = LEN_NONE;
          coll_nxt         = 2'd0;
          hit              = 1'b1;
          pkt.code_index   = rs_r[7:4];
          pkt.event_byte_a = rs_r;
          pkt.event_byte_b = midi_byte;
        end else begin
          exp_len_nxt = LEN_THREE;
          coll_nxt    = 2'd2;
        end
      end
    end else if (coll_r == 2'd0 || coll_r == 2'd3) begin
      exp_len_nxt = LEN_NONE;
      coll_nxt    = 2'd0;
    end else begin
      pb_w[coll_r] = midi_byte;
      pb_nxt       = pb_w;
      if (coll_inc >= exp_len_r) begin
        exp_len_nxt      = LEN_NONE;
        coll_nxt         = 2'd0;
        hit              = 1'b1;
        pkt.code_index   = pcode_r;
        pkt.event_byte_a = pb_w[0];
        pkt.event_byte_b = pb_w[1];
        pkt.event_byte_c = pb_w[2];
      end else begin
        coll_nxt = coll_inc;
      end
    end
  end

  assign emit = accept && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r        <= 8'h00;
      exp_len_r   <= LEN_NONE;
      coll_r      <= 2'd0;
      pcode_r     <= 4'h0;
      pb_r        <= '0;
      sx_active_r <= 1'b0;
      sx_fill_r   <= 2'd0;
    end else if (accept) begin
      rs_r        <= rs_nxt;
      exp_len_r   <= exp_len_nxt;
      coll_r      <= coll_nxt;
      pcode_r     <= pcode_nxt;
      pb_r        <= pb_nxt;
      sx_active_r <= sx_active_nxt;
      sx_fill_r   <= sx_fill_nxt;
    end
  end

endmodule

FILE: rtl/core/mbu_out_buf.sv
module mbu_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbu_pkg::pkt_t push_pkt,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output mbu_pkg::pkt_t out_pkt
);
  import mbu_pkg::*;

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  pkt_t main_r, main_nxt;
  pkt_t skid_r, skid_nxt;
  logic pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_pkt   = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_pkt;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_pkt;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

FILE: rtl/core/midi_byte_to_usb_midi_packet_top.sv
// Converts a serial MIDI byte stream into USB-MIDI event packets on cable 0.
// One byte is taken every clock cycle while the output side has room. A byte
// that completes a packet shows it on the output in the cycle after it is
// accepted, unless an earlier packet still waits there. Parsing state sits in
// one register stage, and a two-entry output register decouples the sides, so
// in_byte.ready falls only when both entries hold packets the sink has not taken.
`include "midi_byte_to_usb_midi_packet_top_defines.svh"

module midi_byte_to_usb_midi_packet_top (
  input  logic      clk,
  input  logic      rst_n,
  mbu_byte_if.sink  in_byte,
  mbu_pkt_if.source out_pkt
);
  import mbu_pkg::*;

  logic in_accept;
  logic emit;
  logic space;
  logic sense_byte;
  pkt_t new_pkt;
  pkt_t held_pkt;

  assign in_byte.ready = space;
  assign in_accept     = in_byte.valid && space;
  assign sense_byte    = (in_byte.midi_byte == MIDI_ACTIVE_SENSE);

  mbu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .midi_byte (in_byte.midi_byte),
    .emit      (emit),
    .pkt       (new_pkt)
  );

  mbu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_pkt  (new_pkt),
    .space     (space),
    .out_valid (out_pkt.valid),
    .out_ready (out_pkt.ready),
    .out_pkt   (held_pkt)
  );

  assign out_pkt.code_index   = held_pkt.code_index;
  assign out_pkt.event_byte_a = held_pkt.event_byte_a;
  assign out_pkt.event_byte_b = held_pkt.event_byte_b;
  assign out_pkt.event_byte_c = held_pkt.event_byte_c;

  `MBU_ASSERT_SAME(a_full_means_valid, clk, rst_n, !in_byte.ready, out_pkt.valid)
  `MBU_ASSERT_SAME(a_emit_on_accept, clk, rst_n, emit, in_byte.valid && in_byte.ready)
  `MBU_ASSERT_SAME(a_sense_dropped, clk, rst_n, in_accept && sense_byte, !emit)
  `MBU_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, out_pkt.valid)

endmodule
